@@ rtl/core/text_console_writer_top_defines.svh @@
// Assertion macros shared by the console RTL.
// Each macro expects i_clk and i_rst_n in scope and checks nothing while reset is low.
`ifndef TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH
`define TEXT_CONSOLE_WRITER_TOP_DEFINES_SVH

// Same-cycle implication.
`define TCW_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define TCW_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/core/tcw_pkg.sv @@
`default_nettype none

package tcw_pkg;

    // One screen cell: attribute in the high byte, character in the low byte.
    typedef struct packed {
        logic [7:0] colour;
        logic [7:0] code;
    } t_cell;

    localparam logic       OP_PUT           = 1'b0;
    localparam logic       OP_READ          = 1'b1;

    localparam logic [7:0] CHAR_BLANK       = 8'h20;
    localparam logic [7:0] CHAR_NEWLINE     = 8'h0A;
    localparam logic [7:0] CHAR_BAD         = 8'hFE;
    localparam logic [7:0] CHAR_FIRST_PRINT = 8'h20;
    localparam logic [7:0] CHAR_LAST_PRINT  = 8'h7E;
    localparam logic [7:0] RESET_COLOUR     = 8'h0E;

    // Bytes outside the printable range are shown as a block character.
    function automatic logic [7:0] tcw_filter(input logic [7:0] raw);
        logic [7:0] res;
        if (raw < CHAR_FIRST_PRINT || raw > CHAR_LAST_PRINT) begin
            res = CHAR_BAD;
        end else begin
            res = raw;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

@@ rtl/core/text_console_writer_top.sv @@
// A put or a read passes from its input transfer to S_DONE, and its result is loaded into
// the result register once that is free. A newline or a put that fills the bottom row first
// passes through S_SCROLL to blank the new row. No item is taken until the last is loaded.
// Reset (synchronous, active low) starts a pass through S_CLEAR that writes blank
// cells to the whole grid; no item is taken until it ends, configuration writes are.
`default_nettype none
`include "text_console_writer_top_defines.svh"

module text_console_writer_top import tcw_pkg::*; #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 25
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // Configuration: text colour register.
    input  wire logic       i_cfg_we,
    input  wire logic [7:0] i_cfg_wdata,
    // Input channel.
    input  wire logic       i_in_valid,
    output      logic       o_in_ready,
    input  wire logic       i_op,
    input  wire logic [7:0] i_char_code,
    input  wire logic [6:0] i_cell_column,
    input  wire logic [4:0] i_cell_row,
    input  wire logic       i_last_of_write,
    // Result channel.
    output      logic       o_out_valid,
    input  wire logic       i_out_ready,
    output      logic [15:0] o_cell_data,
    output      logic [6:0] o_cursor_column,
    output      logic       o_write_done
);

    localparam int DEPTH  = ROWS * COLUMNS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int COL_W  = $clog2(COLUMNS);
    localparam int ROW_W  = $clog2(ROWS);

    // Controller states.
    localparam logic [1:0] S_CLEAR  = 2'd0;
    localparam logic [1:0] S_IDLE   = 2'd1;
    localparam logic [1:0] S_SCROLL = 2'd2;
    localparam logic [1:0] S_DONE   = 2'd3;

    // The grid is kept as a ring of rows. r_top is the physical row shown as row 0,
    // so a scroll only moves r_top and blanks the row that becomes the bottom one.
    logic [1:0]       r_state, n_state;
    logic [ROW_W-1:0] r_top, n_top;
    logic [COL_W-1:0] r_col, n_col;
    logic [COL_W-1:0] r_clr_col, n_clr_col;
    logic [ADDR_W-1:0] r_clr_addr, n_clr_addr;
    logic [7:0]       r_colour;

    // Result of the item in flight, completed in S_DONE.
    logic r_res_read, n_res_read;
    logic r_res_done, n_res_done;

    // Output register parts the result channel from the datapath.
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [6:0]  r_out_col;
    logic        r_out_done;

    // Memory ports.
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    t_cell             ram_wdata;
    logic              ram_re;
    logic [ADDR_W-1:0] ram_raddr;
    logic [15:0]       ram_rdata;

    logic in_xfer;
    logic out_load;
    logic rd_in_range;
    logic [ROW_W:0]    rd_row_sum;
    logic [ROW_W-1:0]  rd_phys;
    logic [ROW_W-1:0]  bottom_phys;
    logic [7:0]        put_char;
    logic              put_newline;
    logic              col_at_end;
    logic [COL_W+6:0]  col_ext;

    tcw_ram #(
        .WIDTH (16),
        .DEPTH (DEPTH)
    ) u_grid (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign o_in_ready = (r_state == S_IDLE);
    assign in_xfer    = i_in_valid && o_in_ready;
    assign out_load   = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    // Read path: map the logical row onto the ring, then into a flat address.
    assign rd_in_range = ({25'd0, i_cell_column} < 32'(COLUMNS))
                      && ({27'd0, i_cell_row} < 32'(ROWS));
    assign rd_row_sum  = {1'b0, r_top} + (ROW_W+1)'(i_cell_row);
    assign rd_phys     = (rd_row_sum >= (ROW_W+1)'(ROWS))
                       ? ROW_W'(rd_row_sum - (ROW_W+1)'(ROWS))
                       : ROW_W'(rd_row_sum);
    assign ram_re      = in_xfer && (i_op == OP_READ) && rd_in_range;
    assign ram_raddr   = ADDR_W'(rd_phys) * ADDR_W'(COLUMNS) + ADDR_W'(i_cell_column);

    // The bottom row sits just above r_top in the ring.
    assign bottom_phys = (r_top == '0) ? ROW_W'(ROWS - 1) : r_top - ROW_W'(1);
    assign put_newline = (i_char_code == CHAR_NEWLINE);
    assign put_char    = tcw_filter(i_char_code);
    assign col_at_end  = (r_col == COL_W'(COLUMNS - 1));

    // Write port: reset pass, character store, or blanking of the new bottom row.
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr_addr;
        ram_wdata = '{colour: RESET_COLOUR, code: CHAR_BLANK};
        unique case (r_state)
            S_CLEAR: begin
                ram_we = 1'b1;
            end
            S_IDLE: begin
                ram_we    = in_xfer && (i_op == OP_PUT) && !put_newline;
                ram_waddr = ADDR_W'(bottom_phys) * ADDR_W'(COLUMNS) + ADDR_W'(r_col);
                ram_wdata = '{colour: r_colour, code: put_char};
            end
            S_SCROLL: begin
                ram_we    = 1'b1;
                ram_waddr = ADDR_W'(r_top) * ADDR_W'(COLUMNS) + ADDR_W'(r_clr_col);
                ram_wdata = '{colour: r_colour, code: CHAR_BLANK};
            end
            S_DONE: begin
                ram_we = 1'b0;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    // Sequencer.
    always_comb begin
        n_state    = r_state;
        n_top      = r_top;
        n_col      = r_col;
        n_clr_col  = r_clr_col;
        n_clr_addr = r_clr_addr;
        n_res_read = r_res_read;
        n_res_done = r_res_done;
        unique case (r_state)
            S_CLEAR: begin
                n_clr_addr = r_clr_addr + ADDR_W'(1);
                if (r_clr_addr == ADDR_W'(DEPTH - 1)) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (in_xfer) begin
                    n_clr_col = '0;
                    if (i_op == OP_READ) begin
                        n_res_read = rd_in_range;
                        n_res_done = 1'b0;
                        n_state    = S_DONE;
                    end else begin
                        n_res_read = 1'b0;
                        n_res_done = i_last_of_write;
                        if (put_newline || col_at_end) begin
                            // The cursor returns to column 0 and the grid scrolls.
                            n_col   = '0;
                            n_state = S_SCROLL;
                        end else begin
                            n_col   = r_col + COL_W'(1);
                            n_state = S_DONE;
                        end
                    end
                end
            end
            S_SCROLL: begin
                n_clr_col = r_clr_col + COL_W'(1);
                if (r_clr_col == COL_W'(COLUMNS - 1)) begin
                    n_top   = (r_top == ROW_W'(ROWS - 1)) ? '0 : r_top + ROW_W'(1);
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (out_load) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLEAR;
            r_top      <= '0;
            r_col      <= '0;
            r_clr_col  <= '0;
            r_clr_addr <= '0;
            r_colour   <= RESET_COLOUR;
            r_out_valid <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_top      <= n_top;
            r_col      <= n_col;
            r_clr_col  <= n_clr_col;
            r_clr_addr <= n_clr_addr;
            if (i_cfg_we) begin
                r_colour <= i_cfg_wdata;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // The cursor column is reported modulo 128 on wide grids.
    assign col_ext = (COL_W+7)'(r_col);

    always_ff @(posedge i_clk) begin
        r_res_read <= n_res_read;
        r_res_done <= n_res_done;
        if (out_load) begin
            // The memory read data holds from the read until this cycle.
            r_out_data <= r_res_read ? ram_rdata : 16'd0;
            r_out_col  <= col_ext[6:0];
            r_out_done <= r_res_done;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_cell_data     = r_out_data;
    assign o_cursor_column = r_out_col;
    assign o_write_done    = r_out_done;

    `TCW_ASSERT_NOW(a_col_in_range, 1'b1, 32'(r_col) < 32'(COLUMNS),
        "cursor column left the grid")
    `TCW_ASSERT_NOW(a_top_in_range, 1'b1, 32'(r_top) < 32'(ROWS),
        "top row pointer left the ring")
    `TCW_ASSERT_NOW(a_scroll_col_zero, r_state == S_SCROLL, r_col == '0,
        "cursor not at column 0 while a row is blanked")
    `TCW_ASSERT_NOW(a_no_write_in_done, r_state == S_DONE, !ram_we,
        "grid written while a result is pending")
    `TCW_ASSERT_NEXT(a_result_loaded, out_load, r_out_valid && r_state == S_IDLE,
        "completed item did not reach the result register")

endmodule

`default_nettype wire

@@ rtl/core/tcw_ram.sv @@
`default_nettype none

module tcw_ram #(
    parameter  int WIDTH  = 16,
    parameter  int DEPTH  = 2000,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  wire logic              i_clk,
    input  wire logic              i_we,
    input  wire logic [ADDR_W-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]  i_wdata,
    input  wire logic              i_re,
    input  wire logic [ADDR_W-1:0] i_raddr,
    output      logic [WIDTH-1:0]  o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire
